// ----- rtl/nms_pkg.sv -----
// Shared types and constants for the edge non-maximum suppression block.
// No dependencies; imported by nms_front, nms_back and the top level.
`default_nettype none

package nms_pkg;

    // Field widths of the stream payloads
    localparam int MAG_W = 8;
    localparam int DIR_W = 2;
    localparam int ROW_W = 12;
    localparam int COL_W = 10;

    // Configuration register map
    localparam int CFG_INDEX_W    = 1;
    localparam int CFG_DATA_W     = 13;
    localparam int WIDTH_FIELD_W  = 11;
    localparam int HEIGHT_FIELD_W = 13;
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

    // Frame geometry limits and reset values
    localparam int MIN_DIM        = 3;
    localparam int DEFAULT_WIDTH  = 640;
    localparam int DEFAULT_HEIGHT = 480;

    // Input commands
    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;

    // Quantized gradient directions
    localparam logic [DIR_W-1:0] DIR_HORIZ     = 2'd0;
    localparam logic [DIR_W-1:0] DIR_DIAG_MAIN = 2'd1;
    localparam logic [DIR_W-1:0] DIR_VERT      = 2'd2;
    localparam logic [DIR_W-1:0] DIR_DIAG_ANTI = 2'd3;

    typedef struct packed {
        logic             command;
        logic [MAG_W-1:0] magnitude;
        logic [DIR_W-1:0] direction;
    } pix_t;

    typedef struct packed {
        logic [MAG_W-1:0] value;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] column;
        logic             frame_end;
    } res_t;

    // Classified transaction handed from the front end to the back end
    typedef struct packed {
        logic             is_data;
        logic             emit;
        logic             border;
        logic [MAG_W-1:0] magnitude;
        logic [DIR_W-1:0] direction;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] column;
        logic             frame_end;
    } cmd_t;

endpackage

`default_nettype wire

// ----- rtl/nms_front.sv -----
// Front end: holds frame geometry, tracks input and output raster positions
// and classifies each transaction. Depends on nms_pkg.
`default_nettype none

module nms_front #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096,
    parameter int CW         = 10,
    parameter int RW         = 12
) (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              cfg_write,
    input  wire [nms_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire [nms_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  wire                              pix_valid,
    input  wire nms_pkg::pix_t               pix,
    input  wire                              q_full,
    output logic                             pix_ready,
    output logic                             push,
    output nms_pkg::cmd_t                    cmd,
    output logic [CW-1:0]                    addr
);
    import nms_pkg::*;

    localparam int WIDTH_RST  = (DEFAULT_WIDTH > MAX_WIDTH) ? MAX_WIDTH : DEFAULT_WIDTH;
    localparam int HEIGHT_RST = (DEFAULT_HEIGHT > MAX_HEIGHT) ? MAX_HEIGHT : DEFAULT_HEIGHT;

    logic [CW-1:0] wlast_reg, wlast_next;
    logic [RW-1:0] hlast_reg, hlast_next;
    logic [CW-1:0] in_col_reg, in_col_next;
    logic [RW-1:0] in_row_reg, in_row_next;
    logic          in_done_reg, in_done_next;
    logic [CW-1:0] out_col_reg, out_col_next;
    logic [RW-1:0] out_row_reg, out_row_next;

    logic        accept;
    logic        take_pixel;
    logic        primed;
    logic        emit;
    logic        out_last_col;
    logic        out_last_row;
    logic        frame_end;
    logic [31:0] w_in;
    logic [31:0] h_in;
    logic [CW-1:0] wlast_clamped;
    logic [RW-1:0] hlast_clamped;

    assign pix_ready = !q_full;
    assign accept    = pix_valid && pix_ready;

    // A pixel produces a result once the window holds a full neighborhood,
    // i.e. from raster position width+1 on.
    assign primed       = (in_row_reg != '0) && ((in_row_reg != RW'(1)) || (in_col_reg != '0));
    assign take_pixel   = (pix.command == CMD_PIXEL) && !in_done_reg;
    assign emit         = (pix.command == CMD_FLUSH) ? in_done_reg : (take_pixel && primed);
    assign out_last_col = (out_col_reg == wlast_reg);
    assign out_last_row = (out_row_reg == hlast_reg);
    assign frame_end    = out_last_col && out_last_row;

    assign push = accept && (take_pixel || emit);
    assign addr = in_col_reg;

    always_comb
    begin
        cmd.is_data   = take_pixel;
        cmd.emit      = emit;
        cmd.border    = (out_row_reg == '0) || out_last_row || (out_col_reg == '0) || out_last_col;
        cmd.magnitude = pix.magnitude;
        cmd.direction = pix.direction;
        cmd.row       = ROW_W'(out_row_reg);
        cmd.column    = COL_W'(out_col_reg);
        cmd.frame_end = frame_end;
    end

    // Register clamping
    always_comb
    begin
        w_in = 32'(cfg_data[WIDTH_FIELD_W-1:0]);
        h_in = 32'(cfg_data[HEIGHT_FIELD_W-1:0]);
        if (w_in < 32'(MIN_DIM))
            wlast_clamped = CW'(MIN_DIM - 1);
        else if (w_in > 32'(MAX_WIDTH))
            wlast_clamped = CW'(MAX_WIDTH - 1);
        else
            wlast_clamped = CW'(w_in - 32'd1);
        if (h_in < 32'(MIN_DIM))
            hlast_clamped = RW'(MIN_DIM - 1);
        else if (h_in > 32'(MAX_HEIGHT))
            hlast_clamped = RW'(MAX_HEIGHT - 1);
        else
            hlast_clamped = RW'(h_in - 32'd1);
    end

    always_comb
    begin
        wlast_next   = wlast_reg;
        hlast_next   = hlast_reg;
        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        in_done_next = in_done_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                REG_IMAGE_WIDTH:  wlast_next = wlast_clamped;
                REG_IMAGE_HEIGHT: hlast_next = hlast_clamped;
                default:          wlast_next = wlast_reg;
            endcase
            in_col_next  = '0;
            in_row_next  = '0;
            in_done_next = 1'b0;
            out_col_next = '0;
            out_row_next = '0;
        end
        else if (accept)
        begin
            if (take_pixel)
            begin
                if (in_col_reg == wlast_reg)
                begin
                    in_col_next = '0;
                    if (in_row_reg == hlast_reg)
                    begin
                        in_row_next  = '0;
                        in_done_next = 1'b1;
                    end
                    else
                        in_row_next = in_row_reg + RW'(1);
                end
                else
                    in_col_next = in_col_reg + CW'(1);
            end
            if (emit)
            begin
                if (frame_end)
                begin
                    // last result of the frame: start over
                    in_col_next  = '0;
                    in_row_next  = '0;
                    in_done_next = 1'b0;
                    out_col_next = '0;
                    out_row_next = '0;
                end
                else if (out_last_col)
                begin
                    out_col_next = '0;
                    out_row_next = out_row_reg + RW'(1);
                end
                else
                    out_col_next = out_col_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wlast_reg   <= CW'(WIDTH_RST - 1);
            hlast_reg   <= RW'(HEIGHT_RST - 1);
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            in_done_reg <= 1'b0;
            out_col_reg <= '0;
            out_row_reg <= '0;
        end
        else
        begin
            wlast_reg   <= wlast_next;
            hlast_reg   <= hlast_next;
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            in_done_reg <= in_done_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/nms_fifo.sv -----
// Short register queue between the front end and the back end.
// No package dependency.
`default_nettype none

module nms_fifo #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 4
) (
    input  wire              clk,
    input  wire              rst_n,
    input  wire              push,
    input  wire [WIDTH-1:0]  din,
    input  wire              pop,
    output logic [WIDTH-1:0] dout,
    output logic             full,
    output logic             empty
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [NW-1:0]    count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == NW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        if (do_push && !do_pop)
            count_next = count_reg + NW'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - NW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= din;
    end

endmodule

`default_nettype wire

// ----- rtl/nms_back.sv -----
// Back end: line stores, 3x3 window and the suppression compare, plus the
// result register. Depends on nms_pkg.
`default_nettype none

module nms_back #(
    parameter int MAX_WIDTH = 1024,
    parameter int CW        = 10
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 q_empty,
    input  wire nms_pkg::cmd_t  q_cmd,
    input  wire [CW-1:0]        q_addr,
    output logic                pop,
    output logic                res_valid,
    input  wire                 res_ready,
    output nms_pkg::res_t       res
);
    import nms_pkg::*;

    // line stores; middle row keeps direction and magnitude together
    logic [MAG_W-1:0]       upper_mem  [MAX_WIDTH];
    logic [DIR_W+MAG_W-1:0] middle_mem [MAX_WIDTH];

    logic [MAG_W-1:0]       rd_up_reg;
    logic [DIR_W+MAG_W-1:0] rd_mid_reg;

    logic          s1_valid_reg;
    cmd_t          s1_cmd_reg;
    logic [CW-1:0] s1_addr_reg;

    // window columns 1 and 2 (column 0 is never read again)
    logic [MAG_W-1:0] win_top1_reg, win_top2_reg;
    logic [MAG_W-1:0] win_mid1_reg, win_mid2_reg;
    logic [MAG_W-1:0] win_bot1_reg, win_bot2_reg;
    logic [DIR_W-1:0] win_dir2_reg;

    res_t res_reg, res_next;
    logic res_valid_reg;

    logic             adv;
    logic             s1_fire;
    logic [MAG_W-1:0] centre;
    logic [MAG_W-1:0] nb_a;
    logic [MAG_W-1:0] nb_b;
    logic [MAG_W-1:0] kept;

    assign adv       = !res_valid_reg || res_ready;
    assign pop       = adv && !q_empty;
    assign s1_fire   = adv && s1_valid_reg;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // Neighbors of the new window centre, taken from the current window
    // plus the column shifting in.
    always_comb
    begin
        centre = win_mid2_reg;
        unique case (win_dir2_reg)
            DIR_HORIZ:
            begin
                nb_a = win_mid1_reg;
                nb_b = rd_mid_reg[MAG_W-1:0];
            end
            DIR_DIAG_MAIN:
            begin
                nb_a = win_top1_reg;
                nb_b = s1_cmd_reg.magnitude;
            end
            DIR_VERT:
            begin
                nb_a = win_top2_reg;
                nb_b = win_bot2_reg;
            end
            DIR_DIAG_ANTI:
            begin
                nb_a = rd_up_reg;
                nb_b = win_bot1_reg;
            end
            default:
            begin
                nb_a = win_mid1_reg;
                nb_b = rd_mid_reg[MAG_W-1:0];
            end
        endcase
        kept = ((centre < nb_a) || (centre < nb_b)) ? '0 : centre;
    end

    always_comb
    begin
        res_next.value     = (s1_cmd_reg.border || !s1_cmd_reg.is_data) ? '0 : kept;
        res_next.row       = s1_cmd_reg.row;
        res_next.column    = s1_cmd_reg.column;
        res_next.frame_end = s1_cmd_reg.frame_end;
    end

    // line stores: middle row read and rewritten on pop, upper row written
    // one stage later with the middle row's old contents
    always_ff @(posedge clk)
    begin
        if (pop && q_cmd.is_data)
        begin
            rd_up_reg          <= upper_mem[q_addr];
            rd_mid_reg         <= middle_mem[q_addr];
            middle_mem[q_addr] <= {q_cmd.direction, q_cmd.magnitude};
        end
        if (s1_fire && s1_cmd_reg.is_data)
            upper_mem[s1_addr_reg] <= rd_mid_reg[MAG_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_cmd_reg  <= q_cmd;
            s1_addr_reg <= q_addr;
        end
        if (s1_fire && s1_cmd_reg.emit)
            res_reg <= res_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
            win_top1_reg  <= '0;
            win_top2_reg  <= '0;
            win_mid1_reg  <= '0;
            win_mid2_reg  <= '0;
            win_bot1_reg  <= '0;
            win_bot2_reg  <= '0;
            win_dir2_reg  <= '0;
        end
        else
        begin
            if (adv)
            begin
                s1_valid_reg  <= pop;
                res_valid_reg <= s1_valid_reg && s1_cmd_reg.emit;
            end
            if (s1_fire && s1_cmd_reg.is_data)
            begin
                win_top1_reg <= win_top2_reg;
                win_top2_reg <= rd_up_reg;
                win_mid1_reg <= win_mid2_reg;
                win_mid2_reg <= rd_mid_reg[MAG_W-1:0];
                win_bot1_reg <= win_bot2_reg;
                win_bot2_reg <= s1_cmd_reg.magnitude;
                win_dir2_reg <= rd_mid_reg[DIR_W+MAG_W-1:MAG_W];
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/edge_non_maximum_suppression_top.sv -----
// Top level of the streaming edge non-maximum suppression block.
// Depends on nms_pkg, nms_front, nms_fifo and nms_back.
//
//  channel  | signals                          | direction | moves
//  ---------+----------------------------------+-----------+------------------------------
//  pixel    | pix_valid, pix_ready, pix        | in        | command, magnitude, direction
//  result   | res_valid, res_ready, res        | out       | value, row, column, frame_end
//  config   | cfg_write, cfg_index, cfg_data   | in        | image_width, image_height
//
// One pixel transaction per clock, sustained while the queue is not full. A result is
// produced in order by the queue write, the line store read and the result register,
// and is offered from that register. The line stores are single-write block memories,
// one per row tap; they need no clearing after reset because unwritten entries only
// feed border pixels, which always give zero.
// rst_n is asynchronous and clears positions, window and handshake state.
// A stalled result port fills the four-entry queue; pix_ready drops only
// when that queue is full.
`default_nettype none

module edge_non_maximum_suppression_top #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096
) (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              cfg_write,
    input  wire [nms_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire [nms_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  wire                              pix_valid,
    output logic                             pix_ready,
    input  wire nms_pkg::pix_t               pix,
    output logic                             res_valid,
    input  wire                              res_ready,
    output nms_pkg::res_t                    res
);
    import nms_pkg::*;

    // column and row counter widths follow the largest frame
    localparam int CW          = $clog2(MAX_WIDTH);
    localparam int RW          = $clog2(MAX_HEIGHT);
    localparam int QUEUE_DEPTH = 4;
    localparam int CMD_W       = $bits(cmd_t);
    localparam int ENTRY_W     = CW + CMD_W;

    logic               push;
    cmd_t               front_cmd;
    logic [CW-1:0]      front_addr;
    logic               q_full;
    logic               q_empty;
    logic               pop;
    logic [ENTRY_W-1:0] q_dout;
    cmd_t               q_cmd;
    logic [CW-1:0]      q_addr;

    // Front end: counts raster positions and decides per transaction whether
    // it touches the line stores, produces a result, or is dropped.
    nms_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .CW         (CW),
        .RW         (RW)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pix_valid (pix_valid),
        .pix       (pix),
        .q_full    (q_full),
        .pix_ready (pix_ready),
        .push      (push),
        .cmd       (front_cmd),
        .addr      (front_addr)
    );

    // Decoupling queue: column address travels with the classified command
    nms_fifo #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .din   ({front_addr, front_cmd}),
        .pop   (pop),
        .dout  (q_dout),
        .full  (q_full),
        .empty (q_empty)
    );

    assign q_cmd  = cmd_t'(q_dout[CMD_W-1:0]);
    assign q_addr = q_dout[ENTRY_W-1:CMD_W];

    // Back end: line stores, window shift, compare and result register
    nms_back #(
        .MAX_WIDTH (MAX_WIDTH),
        .CW        (CW)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_cmd     (q_cmd),
        .q_addr    (q_addr),
        .pop       (pop),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

endmodule

`default_nettype wire
